// File: src/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
// Used by fpba_mem, fpba_scan and fit_policy_block_allocator; no dependencies.
package fpba_pkg;

  // Field widths of the stream items
  localparam int SIZE_W     = 16;
  localparam int IDX_W      = 6;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 7;
  localparam int IN_DATA_W  = 40;  // 38 bits of fields, padded to 5 bytes
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;   // 7 bits of fields, padded to 1 byte
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int WIDE_W     = 9;   // holds any block index or count up to 256

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  // Placement policies (any other code acts as first fit)
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // Configuration handed from the top level to the scanner
  typedef struct packed {
    logic [MODE_W-1:0]  fit_mode;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

  // Scanner states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: src/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: configuration registers and
// stream field mapping. Depends on fpba_pkg, fpba_scan and fpba_mem.
//
// Keeps the free size of up to BLOCKS blocks in a single-port-read memory.
// A load transfer writes one block's size and yields no result.
// An allocate transfer reads the first min(block_count, BLOCKS) entries one
// per cycle through the memory read port, picks a block by first, best or
// worst fit (ties to the lowest index), writes the reduced size back and
// posts one result. An allocate holds the input off until its result is
// posted; first fit ends the scan once a fitting block is found. A finished
// result sits in an output register, so the next transfer is taken while it
// waits. The memory needs no clearing pass: blocks inside block_count must
// be loaded before use.
module fit_policy_block_allocator #(
  parameter int BLOCKS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] block_index, [21:6] block_size, [37:22] request_size, [39:38] zero
  input  logic [fpba_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] kind
  input  logic [fpba_pkg::IN_USER_W-1:0]   in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] granted, [6:1] chosen_block, [7] zero
  output logic [fpba_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import fpba_pkg::*;

  logic [MODE_W-1:0]  fit_mode_r, fit_mode_nxt;
  logic [COUNT_W-1:0] block_count_r, block_count_nxt;
  cfg_t               cfg;

  // configuration register writes
  always_comb begin
    fit_mode_nxt    = fit_mode_r;
    block_count_nxt = block_count_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_MODE:    fit_mode_nxt    = cfg_wdata[MODE_W-1:0];
        CFG_BLOCK_COUNT: block_count_nxt = cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= MODE_FIRST;
      block_count_r <= '0;
    end else begin
      fit_mode_r    <= fit_mode_nxt;
      block_count_r <= block_count_nxt;
    end
  end

  assign cfg.fit_mode    = fit_mode_r;
  assign cfg.block_count = block_count_r;

  fpba_scan #(
    .BLOCKS (BLOCKS)
  ) u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_kind         (in_tuser[0]),
    .in_block_index  (in_tdata[5:0]),
    .in_block_size   (in_tdata[21:6]),
    .in_request_size (in_tdata[37:22]),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

// File: src/fpba_mem.sv
// Free-size store: one write port, one read port with registered read data.
// Depends on fpba_pkg.
module fpba_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [fpba_pkg::SIZE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [fpba_pkg::SIZE_W-1:0] rdata_r
);
  import fpba_pkg::*;

  logic [SIZE_W-1:0] ram [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= ram[raddr];
  end

endmodule

// File: src/fpba_scan.sv
// Allocation sequencer: takes items, scans the free-size store one entry per
// cycle, picks a block by policy, writes back the reduced size, holds result.
// Depends on fpba_pkg and fpba_mem.
module fpba_scan #(
  parameter int BLOCKS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpba_pkg::cfg_t                cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_kind,
  input  logic [fpba_pkg::IDX_W-1:0]    in_block_index,
  input  logic [fpba_pkg::SIZE_W-1:0]   in_block_size,
  input  logic [fpba_pkg::SIZE_W-1:0]   in_request_size,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fpba_pkg::OUT_DATA_W-1:0] out_tdata
);
  import fpba_pkg::*;

  localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CW = $clog2(BLOCKS + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;
  logic [SIZE_W-1:0]     best_size_r, best_size_nxt;
  logic [SIZE_W-1:0]     req_r, req_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [WIDE_W-1:0] blocks_w, count_w, limit_w, load_idx_w, best_idx_w;
  logic [CW-1:0]     limit;
  logic              accept, issue_en, mode_best, mode_worst, mode_first;
  logic              fits, take, scan_done;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [SIZE_W-1:0] mem_wdata, mem_rdata;

  fpba_mem #(
    .DEPTH (BLOCKS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (rd_idx_r[IW-1:0]),
    .rdata_r (mem_rdata)
  );

  // scan limit: block count saturated at the store depth
  assign blocks_w   = WIDE_W'(BLOCKS);
  assign count_w    = {{(WIDE_W-COUNT_W){1'b0}}, cfg.block_count};
  assign limit_w    = (count_w > blocks_w) ? blocks_w : count_w;
  assign limit      = limit_w[CW-1:0];
  assign load_idx_w = {{(WIDE_W-IDX_W){1'b0}}, in_block_index};
  assign best_idx_w = WIDE_W'(best_idx_r);

  assign mode_best  = (cfg.fit_mode == MODE_BEST);
  assign mode_worst = (cfg.fit_mode == MODE_WORST);
  assign mode_first = !mode_best && !mode_worst;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // read issue and candidate compare
  assign issue_en  = (state_r == ST_SCAN) && (rd_idx_r < limit);
  assign fits      = (mem_rdata >= req_r);
  assign take      = cmp_vld_r && fits &&
                     (!found_r ||
                      (mode_best  && (mem_rdata < best_size_r)) ||
                      (mode_worst && (mem_rdata > best_size_r)));
  assign scan_done = (!issue_en && !cmp_vld_r) || (mode_first && found_r);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_vld_nxt   = issue_en;
    cmp_idx_nxt   = rd_idx_r[IW-1:0];
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    req_nxt       = req_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mem_we        = 1'b0;
    mem_waddr     = load_idx_w[IW-1:0];
    mem_wdata     = in_block_size;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            // loads beyond the store are dropped
            mem_we = (load_idx_w < blocks_w);
          end else begin
            state_nxt     = ST_SCAN;
            req_nxt       = in_request_size;
            rd_idx_nxt    = '0;
            found_nxt     = 1'b0;
            best_idx_nxt  = '0;
            best_size_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (issue_en) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (take) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = cmp_idx_r;
          best_size_nxt = mem_rdata;
        end
        if (scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for a free output slot, then write back and post the result
        if (!out_valid_r || out_tready) begin
          mem_we        = found_r;
          mem_waddr     = best_idx_r;
          mem_wdata     = best_size_r - req_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = found_r ? {1'b0, best_idx_w[IDX_W-1:0], 1'b1} : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    req_r       <= req_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
